// ===== rtl/kcd_pkg.sv =====
`default_nettype none

package kcd_pkg;

  // number of scanned keys (1..32); only the first eight have a pin bit
  localparam int unsigned KEYS      = 8;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned KEY_IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;

  // APB register map
  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_DEBOUNCE   = 1'b0;
  localparam logic        REG_LONG_PRESS = 1'b1;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  // per-lane command for one accepted word
  typedef struct packed {
    logic             scan;        // scan tick accepted
    logic             clear;       // read of this key accepted
    logic             low;         // pin reads low
    logic [7:0]       elapsed;
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] long_press;
  } lane_cmd_t;

  // per-lane status toward the merge stage
  typedef struct packed {
    logic   pressed_next;          // pressed state after this word
    event_e pending;               // latched event before this word
  } lane_stat_t;

endpackage : kcd_pkg

`default_nettype wire

// ===== rtl/kcd_lane.sv =====
`default_nettype none

module kcd_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kcd_pkg::lane_cmd_t cmd_i,
  output kcd_pkg::lane_stat_t stat_o
);
  import kcd_pkg::*;

  // held_q: time since press start; since_q: time since last long click
  logic [TIME_W-1:0] held_q, held_d, since_q, since_d;
  logic              tracking_q, tracking_d;
  logic              pressed_q, pressed_d;
  event_e            event_q, event_d;

  logic [TIME_W-1:0] held_n, since_n, deb_w, lp_w;

  assign held_n  = held_q + TIME_W'(cmd_i.elapsed);
  assign since_n = since_q + TIME_W'(cmd_i.elapsed);
  assign deb_w   = TIME_W'(cmd_i.debounce);
  assign lp_w    = TIME_W'(cmd_i.long_press);

  // key timing on a scan tick, event clear on a read
  always_comb begin
    held_d     = held_q;
    since_d    = since_q;
    tracking_d = tracking_q;
    pressed_d  = pressed_q;
    event_d    = event_q;
    if (cmd_i.scan) begin
      since_d = since_n;
      if (cmd_i.low) begin
        if (!tracking_q) begin
          tracking_d = 1'b1;
          held_d     = '0;
        end else begin
          held_d = held_n;
          if (held_n > deb_w) begin
            pressed_d = 1'b1;
            if (held_n > lp_w && since_n > lp_w) begin
              event_d = EV_LONG;
              since_d = '0;
            end
          end
        end
      end else begin
        if (pressed_q && tracking_q && held_n < lp_w) begin
          event_d = EV_CLICK;
        end
        pressed_d  = 1'b0;
        tracking_d = 1'b0;
      end
    end else if (cmd_i.clear) begin
      event_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      since_q    <= '0;
      tracking_q <= 1'b0;
      pressed_q  <= 1'b0;
      event_q    <= EV_NONE;
    end else begin
      held_q     <= held_d;
      since_q    <= since_d;
      tracking_q <= tracking_d;
      pressed_q  <= pressed_d;
      event_q    <= event_d;
    end
  end

  assign stat_o.pressed_next = pressed_d;
  assign stat_o.pending      = event_q;

  a_pressed_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressed_q |-> tracking_q)
    else $error("pressed key without timing");

  a_event_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_q != 2'd3)
    else $error("illegal event code");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clear && !cmd_i.scan) |=> event_q == EV_NONE)
    else $error("read did not clear event");

  a_release_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan && !cmd_i.low) |=> (!tracking_q && !pressed_q))
    else $error("released key still timed");

endmodule : kcd_lane

`default_nettype wire

// ===== rtl/kcd_merge.sv =====
`default_nettype none

module kcd_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          op_read_i,
  input  logic [kcd_pkg::KEY_IDX_W-1:0] sel_i,
  input  kcd_pkg::lane_stat_t           stat_i [kcd_pkg::KEYS],
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    event_code_o,
  output logic [kcd_pkg::MASK_W-1:0]    pressed_mask_o,
  output logic                          selected_pressed_o
);
  import kcd_pkg::*;

  logic              valid_q;
  logic [1:0]        event_q;
  logic [MASK_W-1:0] mask_q;
  logic              sel_q;

  logic [MASK_W-1:0] mask_d;
  logic [1:0]        event_d;

  // collect the pressed bits of keys that have a pin
  always_comb begin
    mask_d = '0;
    for (int i = 0; i < KEYS; i++) begin
      if (i < MASK_W) begin
        mask_d[i] = stat_i[i].pressed_next;
      end
    end
  end

  assign event_d = op_read_i ? stat_i[sel_i].pending : EV_NONE;

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      event_q <= event_d;
      mask_q  <= mask_d;
      sel_q   <= stat_i[sel_i].pressed_next;
    end
  end

  assign out_valid_o        = valid_q;
  assign event_code_o       = event_q;
  assign pressed_mask_o     = mask_q;
  assign selected_pressed_o = sel_q;

endmodule : kcd_merge

`default_nettype wire

// ===== rtl/key_click_long_press_detector.sv =====
// Key scanner with click and long-click detection for up to 32 active-low
// keys, one lane per key. A word with tuser = 0 is a scan tick: the time
// base advances by elapsed_ms, then every key is timed; a key held past
// debounce_ms is pressed, held past long_press_ms it latches a long click
// (repeated each long_press_ms), released while pressed before long_press_ms
// it latches a click. A word with tuser = 1 reads and clears the event of
// key_index (clamped to the last key). Every word yields one result word in
// the next cycle; one word is accepted per clock while the result stream
// does not stall, and input is taken while a result waits as long as the
// result is taken in the same cycle. Registers: debounce_ms at 0x0,
// long_press_ms at 0x4; write them only while the block is idle.

`default_nettype none

module key_click_long_press_detector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kcd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // key_levels, elapsed_ms, key_index
  input  logic                        s_axis_tuser,  // operation
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata   // event_code, pressed_mask,
                                                     // selected_pressed, zero pad
);
  import kcd_pkg::*;

  logic [CFG_W-1:0] debounce_q, long_press_q;
  logic             cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DEBOUNCE:   debounce_q   <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS: long_press_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE:   prdata = 32'(debounce_q);
      REG_LONG_PRESS: prdata = 32'(long_press_q);
      default:        prdata = '0;
    endcase
  end

  // input word decode
  logic                 out_valid, fire, op_read;
  logic [LEVEL_W-1:0]   levels;
  logic [7:0]           elapsed, key_index;
  logic [KEY_IDX_W-1:0] sel;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign op_read       = (op_e'(s_axis_tuser) == OP_READ);
  assign levels        = s_axis_tdata[7:0];
  assign elapsed       = s_axis_tdata[15:8];
  assign key_index     = s_axis_tdata[23:16];
  assign sel           = (key_index > 8'(KEYS - 1)) ? KEY_IDX_W'(KEYS - 1)
                                                    : KEY_IDX_W'(key_index);

  // key lanes
  lane_cmd_t  cmd  [KEYS];
  lane_stat_t stat [KEYS];

  for (genvar g = 0; g < KEYS; g++) begin : g_lane
    always_comb begin
      cmd[g].scan       = fire && !op_read;
      cmd[g].clear      = fire && op_read && (sel == KEY_IDX_W'(g));
      cmd[g].low        = (g < LEVEL_W) ? !levels[g % LEVEL_W] : 1'b0;
      cmd[g].elapsed    = elapsed;
      cmd[g].debounce   = debounce_q;
      cmd[g].long_press = long_press_q;
    end

    kcd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .stat_o (stat[g])
    );
  end

  // merge and output register
  logic [1:0]        event_code;
  logic [MASK_W-1:0] pressed_mask;
  logic              selected_pressed;

  kcd_merge u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fire_i             (fire),
    .op_read_i          (op_read),
    .sel_i              (sel),
    .stat_i             (stat),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (out_valid),
    .event_code_o       (event_code),
    .pressed_mask_o     (pressed_mask),
    .selected_pressed_o (selected_pressed)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, selected_pressed, pressed_mask, event_code};

endmodule : key_click_long_press_detector

`default_nettype wire
